// ===== rtl/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/dqnp_pkg.sv =====
package dqnp_pkg;

    localparam int DEF_PACKET_DEPTH  = 512;
    localparam int DEF_NAME_CAPACITY = 256;

    localparam int          HEADER_BYTES = 12;
    localparam logic [15:0] QCOUNT_RESET = 16'd10;
    localparam logic [7:0]  JUMPS_RESET  = 8'd16;
    localparam logic [7:0]  DOT_CHAR     = 8'h2E;
    localparam logic [1:0]  POINTER_MARK = 2'b11;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 112;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_QCOUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMPS  = 8'd1;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_SHORT     = 3'd1,
        STAT_BAD_COUNT = 3'd2,
        STAT_BAD_NAME  = 3'd3,
        STAT_TRUNC     = 3'd4,
        STAT_OVERFLOW  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        ST_COLLECT, ST_CHECK, ST_NRD, ST_NEV, ST_PTR, ST_LRD, ST_LWR, ST_DOT,
        ST_ZRD, ST_ZEV, ST_QRD, ST_QEV, ST_ERD, ST_EWR, ST_EOUT, ST_FIN
    } state_t;

endpackage

// ===== rtl/dqnp_ram.sv =====
module dqnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/dns_query_name_parser_core.sv =====
// sequence: bytes taken one per cycle while collecting; after the last beat a check state,
// then the name walk reads each label length, copies each character, writes a dot per label,
// stops at the closing zero or follows pointer hops, scans for a zero from offset 12 and reads type and class
// output: name characters packed into chunk beats of up to eight bytes, then the status beat
// throughput: one packet at a time, input stalls from the last beat until the status beat
// reset: synchronous active-low aresetn clears control state and loads the config defaults
module dns_query_name_parser_core #(
    parameter int PACKET_DEPTH  = dqnp_pkg::DEF_PACKET_DEPTH,
    parameter int NAME_CAPACITY = dqnp_pkg::DEF_NAME_CAPACITY
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dqnp_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,   // last_byte
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] name_chunk, [67:64] chunk_bytes, [70:68] parse_status,
    // [78:71] name_length, [94:79] query_type, [110:95] query_class, [111] zero
    output logic [dqnp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,   // final_result
    // config writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dqnp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dqnp_pkg::CFG_DAT_W-1:0]  cfg_data
);
    localparam int PA = $clog2(PACKET_DEPTH);   // packet address bits
    localparam int CW = PA + 1;                 // byte count / cursor bits
    localparam int NA = $clog2(NAME_CAPACITY);  // name address bits
    localparam int NW = NA + 1;                 // name fill bits

    dqnp_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic [7:0]     qd_hi_reg, qd_hi_next, qd_lo_reg, qd_lo_next;
    logic [15:0]    maxq_reg, maxq_next;
    logic [7:0]     maxj_reg, maxj_next;
    logic [CW-1:0]  cur_reg, cur_next;
    logic [7:0]     jumps_reg, jumps_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [7:0]     rem_reg, rem_next;
    logic [7:0]     b_reg, b_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic [31:0]    q_reg, q_next;
    logic [1:0]     qi_reg, qi_next;
    logic [2:0]     status_reg, status_next;
    logic [7:0]     nlen_reg, nlen_next;
    logic [7:0]     idx_reg, idx_next;
    logic [63:0]    chunk_reg, chunk_next;
    logic [3:0]     cb_reg, cb_next;

    // memory ports
    logic           pkt_we;
    logic [PA-1:0]  pkt_raddr;
    logic [7:0]     pkt_rdata;
    logic           nm_we;
    logic [NA-1:0]  nm_waddr, nm_raddr;
    logic [7:0]     nm_wdata, nm_rdata;

    logic           s_beat, m_beat;
    logic [15:0]    qd;
    logic [CW:0]    label_end;
    logic [9:0]     name_need;
    logic [13:0]    ptr_off;
    logic [CW:0]    cur_plus1, pos_plus5;

    assign s_beat    = s_tvalid && s_tready;
    assign m_beat    = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;
    assign qd        = {qd_hi_reg, qd_lo_reg};
    // label runs from cur+1 for pkt_rdata bytes
    assign label_end = {1'b0, cur_reg} + (CW+1)'(pkt_rdata) + (CW+1)'(1);
    assign name_need = 10'(n_reg) + 10'(pkt_rdata) + 10'd1;
    assign ptr_off   = {b_reg[5:0], pkt_rdata};
    assign cur_plus1 = {1'b0, cur_reg} + (CW+1)'(1);
    assign pos_plus5 = {1'b0, pos_reg} + (CW+1)'(5);

    dqnp_ram #(.WIDTH(8), .DEPTH(PACKET_DEPTH)) u_pkt_ram (
        .aclk  (aclk),
        .we    (pkt_we),
        .waddr (count_reg[PA-1:0]),
        .wdata (s_tdata[7:0]),
        .raddr (pkt_raddr),
        .rdata (pkt_rdata)
    );

    dqnp_ram #(.WIDTH(8), .DEPTH(NAME_CAPACITY)) u_name_ram (
        .aclk  (aclk),
        .we    (nm_we),
        .waddr (nm_waddr),
        .wdata (nm_wdata),
        .raddr (nm_raddr),
        .rdata (nm_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dqnp_pkg::ST_COLLECT;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            maxq_reg  <= dqnp_pkg::QCOUNT_RESET;
            maxj_reg  <= dqnp_pkg::JUMPS_RESET;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            maxq_reg  <= maxq_next;
            maxj_reg  <= maxj_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        qd_hi_reg  <= qd_hi_next;
        qd_lo_reg  <= qd_lo_next;
        cur_reg    <= cur_next;
        jumps_reg  <= jumps_next;
        n_reg      <= n_next;
        rem_reg    <= rem_next;
        b_reg      <= b_next;
        pos_reg    <= pos_next;
        q_reg      <= q_next;
        qi_reg     <= qi_next;
        status_reg <= status_next;
        nlen_reg   <= nlen_next;
        idx_reg    <= idx_next;
        chunk_reg  <= chunk_next;
        cb_reg     <= cb_next;
    end

    // next state and datapath updates
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        qd_hi_next  = qd_hi_reg;
        qd_lo_next  = qd_lo_reg;
        maxq_next   = maxq_reg;
        maxj_next   = maxj_reg;
        cur_next    = cur_reg;
        jumps_next  = jumps_reg;
        n_next      = n_reg;
        rem_next    = rem_reg;
        b_next      = b_reg;
        pos_next    = pos_reg;
        q_next      = q_reg;
        qi_next     = qi_reg;
        status_next = status_reg;
        nlen_next   = nlen_reg;
        idx_next    = idx_reg;
        chunk_next  = chunk_reg;
        cb_next     = cb_reg;

        if (cfg_valid && cfg_ready) begin
            if (cfg_index == dqnp_pkg::CFG_MAX_QCOUNT) begin
                maxq_next = cfg_data;
            end else if (cfg_index == dqnp_pkg::CFG_MAX_JUMPS) begin
                maxj_next = cfg_data[7:0];
            end
        end

        case (state_reg)
            dqnp_pkg::ST_COLLECT: begin
                if (s_beat) begin
                    if (count_reg < CW'(PACKET_DEPTH)) begin
                        // keep the question count bytes in registers
                        if (count_reg == CW'(4)) qd_hi_next = s_tdata[7:0];
                        if (count_reg == CW'(5)) qd_lo_next = s_tdata[7:0];
                        count_next = count_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) state_next = dqnp_pkg::ST_CHECK;
                end
            end
            dqnp_pkg::ST_CHECK: begin
                nlen_next  = '0;
                q_next     = '0;
                cur_next   = CW'(dqnp_pkg::HEADER_BYTES);
                jumps_next = '0;
                n_next     = '0;
                state_next = dqnp_pkg::ST_FIN;
                if (ovf_reg) begin
                    status_next = dqnp_pkg::STAT_OVERFLOW;
                end else if (count_reg < CW'(dqnp_pkg::HEADER_BYTES)) begin
                    status_next = dqnp_pkg::STAT_SHORT;
                end else if (qd == 16'd0 || qd > maxq_reg) begin
                    status_next = dqnp_pkg::STAT_BAD_COUNT;
                end else if (count_reg == CW'(dqnp_pkg::HEADER_BYTES)) begin
                    status_next = dqnp_pkg::STAT_SHORT;
                end else begin
                    status_next = dqnp_pkg::STAT_OK;
                    state_next  = dqnp_pkg::ST_NRD;
                end
            end
            dqnp_pkg::ST_NRD: begin
                // name walk continues while inside the packet and under the jump limit
                if (cur_reg < count_reg && jumps_reg < maxj_reg) begin
                    state_next = dqnp_pkg::ST_NEV;
                end else begin
                    status_next = dqnp_pkg::STAT_BAD_NAME;
                    state_next  = dqnp_pkg::ST_FIN;
                end
            end
            dqnp_pkg::ST_NEV: begin
                if (pkt_rdata == 8'd0) begin
                    // root terminator: drop trailing dot
                    nlen_next  = (n_reg != '0) ? 8'(n_reg - NW'(1)) : 8'd0;
                    pos_next   = CW'(dqnp_pkg::HEADER_BYTES);
                    state_next = dqnp_pkg::ST_ZRD;
                end else if (pkt_rdata[7:6] == dqnp_pkg::POINTER_MARK) begin
                    if (cur_plus1 >= {1'b0, count_reg}) begin
                        status_next = dqnp_pkg::STAT_BAD_NAME;
                        state_next  = dqnp_pkg::ST_FIN;
                    end else begin
                        b_next     = pkt_rdata;
                        state_next = dqnp_pkg::ST_PTR;
                    end
                end else if (label_end > {1'b0, count_reg} ||
                             name_need > 10'(NAME_CAPACITY)) begin
                    status_next = dqnp_pkg::STAT_BAD_NAME;
                    state_next  = dqnp_pkg::ST_FIN;
                end else begin
                    cur_next   = cur_plus1[CW-1:0];
                    rem_next   = pkt_rdata;
                    state_next = dqnp_pkg::ST_LRD;
                end
            end
            dqnp_pkg::ST_PTR: begin
                // pointers must go strictly backward
                if (ptr_off >= 14'(cur_reg)) begin
                    status_next = dqnp_pkg::STAT_BAD_NAME;
                    state_next  = dqnp_pkg::ST_FIN;
                end else begin
                    cur_next   = ptr_off[CW-1:0];
                    jumps_next = jumps_reg + 8'd1;
                    state_next = dqnp_pkg::ST_NRD;
                end
            end
            dqnp_pkg::ST_LRD: begin
                state_next = dqnp_pkg::ST_LWR;
            end
            dqnp_pkg::ST_LWR: begin
                n_next   = n_reg + NW'(1);
                cur_next = cur_reg + CW'(1);
                rem_next = rem_reg - 8'd1;
                state_next = (rem_reg == 8'd1) ? dqnp_pkg::ST_DOT : dqnp_pkg::ST_LRD;
            end
            dqnp_pkg::ST_DOT: begin
                n_next     = n_reg + NW'(1);
                state_next = dqnp_pkg::ST_NRD;
            end
            dqnp_pkg::ST_ZRD: begin
                // scan for the first zero past the header
                if (pos_reg >= count_reg) begin
                    status_next = dqnp_pkg::STAT_TRUNC;
                    nlen_next   = '0;
                    state_next  = dqnp_pkg::ST_FIN;
                end else begin
                    state_next = dqnp_pkg::ST_ZEV;
                end
            end
            dqnp_pkg::ST_ZEV: begin
                if (pkt_rdata == 8'd0) begin
                    if (pos_plus5 > {1'b0, count_reg}) begin
                        status_next = dqnp_pkg::STAT_TRUNC;
                        nlen_next   = '0;
                        state_next  = dqnp_pkg::ST_FIN;
                    end else begin
                        pos_next   = pos_reg + CW'(1);
                        qi_next    = '0;
                        state_next = dqnp_pkg::ST_QRD;
                    end
                end else begin
                    pos_next   = pos_reg + CW'(1);
                    state_next = dqnp_pkg::ST_ZRD;
                end
            end
            dqnp_pkg::ST_QRD: begin
                state_next = dqnp_pkg::ST_QEV;
            end
            dqnp_pkg::ST_QEV: begin
                q_next   = {q_reg[23:0], pkt_rdata};
                pos_next = pos_reg + CW'(1);
                qi_next  = qi_reg + 2'd1;
                idx_next   = '0;
                chunk_next = '0;
                cb_next    = '0;
                if (qi_reg == 2'd3) begin
                    state_next = (nlen_reg != 8'd0) ? dqnp_pkg::ST_ERD : dqnp_pkg::ST_FIN;
                end else begin
                    state_next = dqnp_pkg::ST_QRD;
                end
            end
            dqnp_pkg::ST_ERD: begin
                state_next = dqnp_pkg::ST_EWR;
            end
            dqnp_pkg::ST_EWR: begin
                chunk_next[cb_reg[2:0]*8 +: 8] = nm_rdata;
                cb_next  = cb_reg + 4'd1;
                idx_next = idx_reg + 8'd1;
                if (cb_reg == 4'd7 || (idx_reg + 8'd1) == nlen_reg) begin
                    state_next = dqnp_pkg::ST_EOUT;
                end else begin
                    state_next = dqnp_pkg::ST_ERD;
                end
            end
            dqnp_pkg::ST_EOUT: begin
                if (m_beat) begin
                    chunk_next = '0;
                    cb_next    = '0;
                    state_next = (idx_reg == nlen_reg) ? dqnp_pkg::ST_FIN : dqnp_pkg::ST_ERD;
                end
            end
            dqnp_pkg::ST_FIN: begin
                if (m_beat) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = dqnp_pkg::ST_COLLECT;
                end
            end
            default: begin
                state_next = dqnp_pkg::ST_COLLECT;
            end
        endcase
    end

    // memory controls and handshake outputs
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        m_tlast   = 1'b0;
        m_tdata   = '0;
        pkt_we    = 1'b0;
        pkt_raddr = cur_reg[PA-1:0];
        nm_we     = 1'b0;
        nm_waddr  = n_reg[NA-1:0];
        nm_wdata  = pkt_rdata;
        nm_raddr  = idx_reg[NA-1:0];
        case (state_reg)
            dqnp_pkg::ST_COLLECT: begin
                s_tready = 1'b1;
                pkt_we   = s_tvalid && (count_reg < CW'(PACKET_DEPTH));
            end
            dqnp_pkg::ST_NEV: begin
                // second pointer byte
                pkt_raddr = cur_plus1[PA-1:0];
            end
            dqnp_pkg::ST_LWR: begin
                nm_we = 1'b1;
            end
            dqnp_pkg::ST_DOT: begin
                nm_we    = 1'b1;
                nm_wdata = dqnp_pkg::DOT_CHAR;
            end
            dqnp_pkg::ST_ZRD, dqnp_pkg::ST_QRD: begin
                pkt_raddr = pos_reg[PA-1:0];
            end
            dqnp_pkg::ST_EOUT: begin
                m_tvalid       = 1'b1;
                m_tdata[63:0]  = chunk_reg;
                m_tdata[67:64] = cb_reg;
            end
            dqnp_pkg::ST_FIN: begin
                m_tvalid        = 1'b1;
                m_tlast         = 1'b1;
                m_tdata[70:68]  = status_reg;
                m_tdata[78:71]  = nlen_reg;
                m_tdata[94:79]  = q_reg[31:16];
                m_tdata[110:95] = q_reg[15:0];
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== rtl/dqnp_checker.sv =====
`include "assert_macros.svh"

module dqnp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic         m_tlast
);
    // a stalled result beat holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // input is never taken while results are pending
    `ASSERT_SAME(a_excl, aclk, aresetn, m_tvalid, !s_tready)
    // status beat carries no characters
    `ASSERT_SAME(a_fin, aclk, aresetn, m_tvalid && m_tlast, m_tdata[67:64] == 4'd0)
    // chunk beats carry one to eight characters and no status
    `ASSERT_SAME(a_chunk, aclk, aresetn, m_tvalid && !m_tlast,
        m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd8 && m_tdata[110:68] == 43'd0)
endmodule

bind dns_query_name_parser_core dqnp_checker u_dqnp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
